// ===== rtl/dspg_pkg.sv =====
// Shared types, codes and constants for the dual servo pulse generator.
// No dependencies; imported by every module of the block and of its bench.
`timescale 1ns / 1ps

package dspg_pkg;

   // Field and register widths
   localparam int MODE_W     = 2;
   localparam int ID_W       = 2;
   localparam int POS_W      = 8;
   localparam int TMO_W      = 16;
   localparam int TICK_W     = 8;
   localparam int UPTIME_W   = 32;
   localparam int INTERVAL_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int NUM_SERVOS_DEF = 2;

   // Frame length in ms; an accepted timeout must exceed it
   localparam logic [TMO_W-1:0] FRAME_MS   = TMO_W'(20);
   localparam logic [POS_W-1:0] CENTRE_POS = POS_W'(128);

   // Command codes
   localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SET     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SET_TMO = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd3;

   // Servo ids
   localparam logic [ID_W-1:0] SERVO_Z = 2'd0;
   localparam logic [ID_W-1:0] SERVO_X = 2'd1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_REVERSE_Z       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POWER_OFF_CODE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_DELAY     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_TICKS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_PERIOD     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_REPEATS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_UPDATE_INTERVAL = 3'd6;

   // Register reset values
   localparam logic [TICK_W-1:0]     START_DELAY_RST = 8'd129;
   localparam logic [TICK_W-1:0]     STEP_TICKS_RST  = 8'd2;
   localparam logic [TICK_W-1:0]     STOP_PERIOD_RST = 8'd255;
   localparam logic [TICK_W-1:0]     STOP_REPEATS_RST = 8'd19;
   localparam logic [INTERVAL_W-1:0] UPDATE_INTERVAL_RST = 16'd500;

   // Frame phase
   typedef enum logic [2:0] {
      PH_START  = 3'b001,
      PH_SWEEP  = 3'b010,
      PH_FILLER = 3'b100
   } phase_type;

   // Item sequencer
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_REM  = 2'b10
   } seq_state_type;

   // Handshake between sequencer and remainder unit
   typedef struct packed {
      logic done;
      logic rem_zero;
   } rem_status_type;

endpackage

// ===== rtl/dspg_rem_unit.sv =====
// Bit-serial remainder unit: uptime modulo update interval, one bit a cycle.
// Depends on dspg_pkg for widths and the status struct.
`timescale 1ns / 1ps

module dspg_rem_unit
   import dspg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [UPTIME_W-1:0]   dividend,
   input  logic [INTERVAL_W-1:0] divisor,
   output rem_status_type        status
);

   localparam int CNT_W = $clog2(UPTIME_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(UPTIME_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [UPTIME_W-1:0]   dvd_ff, dvd_in;
   logic [INTERVAL_W-1:0] dsr_ff, dsr_in;
   logic [INTERVAL_W-1:0] rem_ff, rem_in;
   logic [INTERVAL_W:0]   trial;
   logic [INTERVAL_W:0]   diff;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, dvd_ff[UPTIME_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[UPTIME_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[INTERVAL_W-1:0];
         end else begin
            rem_in = trial[INTERVAL_W-1:0];
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

// ===== rtl/dual_servo_pwm_generator.sv =====
// Dual servo pulse generator: frame timer, command decode and item sequencer.
// An item's result is registered in the cycle after its acceptance; a tick that
// starts a frame with a non-zero update interval waits for the 32 one-bit steps
// of the shared remainder unit. One item at a time is in work.
// Synchronous active-high reset; servos at centre, pins low, filler phase.
// Depends on dspg_pkg and dspg_rem_unit.
`timescale 1ns / 1ps

module dual_servo_pwm_generator
   import dspg_pkg::*;
#(
   parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // item input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [ID_W-1:0]       req_servo_id,
   input  logic [POS_W-1:0]      req_position,
   input  logic [TMO_W-1:0]      req_timeout_ms,
   // result output
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_pin_z,
   output logic                  rsp_pin_x,
   output logic [POS_W-1:0]      rsp_read_value,
   output logic                  rsp_update_pulse,
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   logic                  reverse_z_ff;
   logic [POS_W-1:0]      power_off_code_ff;
   logic [TICK_W-1:0]     start_delay_ff;
   logic [TICK_W-1:0]     step_ticks_ff;
   logic [TICK_W-1:0]     stop_period_ff;
   logic [TICK_W-1:0]     stop_repeats_ff;
   logic [INTERVAL_W-1:0] update_interval_ff;

   // Frame and servo state
   phase_type             phase_ff, phase_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [TICK_W-1:0]     step_ff, step_in;
   logic [POS_W-1:0]      pos_ff [NUM_SERVOS];
   logic [POS_W-1:0]      pos_in [NUM_SERVOS];
   logic [NUM_SERVOS-1:0] pins_ff, pins_in;
   logic [UPTIME_W-1:0]   uptime_ff, uptime_in;
   logic [TMO_W-1:0]      stop_ff, stop_in;

   // Sequencer and result registers
   seq_state_type         state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_pin_z_ff, rsp_pin_x_ff;
   logic [POS_W-1:0]      rsp_read_value_ff;
   logic                  rsp_update_pulse_ff;

   logic                  req_fire;
   logic                  frame_start;
   logic                  rem_start;
   logic [TICK_W-1:0]     period;
   logic [TICK_W-1:0]     tick_inc;
   logic [TICK_W-1:0]     step_inc;
   logic [TMO_W-1:0]      stop_dec;
   logic                  id_ok;
   logic                  rev_id;
   logic [POS_W-1:0]      set_pos;
   logic [POS_W-1:0]      raw_rd;
   logic [POS_W-1:0]      rd_value;
   logic                  pin_x_next;
   rem_status_type        rem_status;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   // Configuration register file
   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_z_ff       <= 1'b0;
         power_off_code_ff  <= '0;
         start_delay_ff     <= START_DELAY_RST;
         step_ticks_ff      <= STEP_TICKS_RST;
         stop_period_ff     <= STOP_PERIOD_RST;
         stop_repeats_ff    <= STOP_REPEATS_RST;
         update_interval_ff <= UPDATE_INTERVAL_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_REVERSE_Z:       reverse_z_ff       <= csr_wdata[0];
            REG_POWER_OFF_CODE:  power_off_code_ff  <= csr_wdata[POS_W-1:0];
            REG_START_DELAY:     start_delay_ff     <= csr_wdata[TICK_W-1:0];
            REG_STEP_TICKS:      step_ticks_ff      <= csr_wdata[TICK_W-1:0];
            REG_STOP_PERIOD:     stop_period_ff     <= csr_wdata[TICK_W-1:0];
            REG_STOP_REPEATS:    stop_repeats_ff    <= csr_wdata[TICK_W-1:0];
            REG_UPDATE_INTERVAL: update_interval_ff <= csr_wdata[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   // Period of the current phase
   always_comb begin
      unique case (phase_ff)
         PH_START: period = start_delay_ff;
         PH_SWEEP: period = step_ticks_ff;
         default:  period = stop_period_ff;
      endcase
   end

   assign tick_inc = tick_ff + TICK_W'(1);
   assign step_inc = step_ff + TICK_W'(1);
   assign stop_dec = stop_ff - FRAME_MS;
   assign id_ok    = (int'(req_servo_id) < 2) && (int'(req_servo_id) < NUM_SERVOS);
   assign rev_id   = reverse_z_ff && (req_servo_id == SERVO_Z);

   // Position with z inversion applied (power-off code passes unchanged)
   assign set_pos = (rev_id && (req_position != power_off_code_ff)) ?
                    ~req_position : req_position;

   // Stored position of the addressed servo
   always_comb begin
      raw_rd = '0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
         if (int'(req_servo_id) == i) begin
            raw_rd = pos_ff[i];
         end
      end
   end

   // Next state for one item
   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      step_in     = step_ff;
      pos_in      = pos_ff;
      pins_in     = pins_ff;
      uptime_in   = uptime_ff;
      stop_in     = stop_ff;
      frame_start = 1'b0;
      rd_value    = '0;
      if (req_mode == MODE_TICK) begin
         if (tick_inc < period) begin
            tick_in = tick_inc;
         end else begin
            tick_in = '0;
            unique case (phase_ff)
               PH_START: begin
                  phase_in = PH_SWEEP;
                  step_in  = TICK_W'(1);
                  for (int i = 0; i < NUM_SERVOS; i++) begin
                     if (pos_ff[i] < POS_W'(1)) pins_in[i] = 1'b0;
                  end
               end
               PH_SWEEP: begin
                  step_in = step_inc;
                  if (step_inc == '0) begin
                     phase_in = PH_FILLER;
                  end else begin
                     for (int i = 0; i < NUM_SERVOS; i++) begin
                        if (pos_ff[i] < step_inc) pins_in[i] = 1'b0;
                     end
                  end
               end
               default: begin
                  step_in = step_inc;
                  if (step_inc > stop_repeats_ff) begin
                     // new frame: raise pins, advance uptime, run down timeout
                     frame_start = 1'b1;
                     phase_in    = PH_START;
                     for (int i = 0; i < NUM_SERVOS; i++) begin
                        if (pos_ff[i] != power_off_code_ff) pins_in[i] = 1'b1;
                     end
                     uptime_in = uptime_ff + UPTIME_W'(FRAME_MS);
                     if (stop_ff != '0) begin
                        if (stop_dec < FRAME_MS) begin
                           stop_in = '0;
                           for (int i = 0; i < NUM_SERVOS; i++) begin
                              pos_in[i] = power_off_code_ff;
                           end
                        end else begin
                           stop_in = stop_dec;
                        end
                     end
                  end
               end
            endcase
         end
      end else if (id_ok) begin
         unique case (req_mode)
            MODE_SET: begin
               for (int i = 0; i < NUM_SERVOS; i++) begin
                  pos_in[i] = (int'(req_servo_id) == i) ? set_pos : power_off_code_ff;
               end
            end
            MODE_SET_TMO: begin
               if (req_timeout_ms > FRAME_MS) begin
                  stop_in = req_timeout_ms;
                  for (int i = 0; i < NUM_SERVOS; i++) begin
                     if (int'(req_servo_id) == i) pos_in[i] = set_pos;
                  end
               end
            end
            default: begin
               rd_value = (rev_id && (raw_rd != power_off_code_ff)) ? ~raw_rd : raw_rd;
            end
         endcase
      end
   end

   assign pin_x_next = (NUM_SERVOS > 1) ? pins_in[(NUM_SERVOS > 1) ? 1 : 0] : 1'b0;
   assign rem_start  = req_fire && frame_start && (update_interval_ff != '0);

   // Item sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (rem_start) begin
                  state_in = ST_REM;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            if (rem_status.done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_FILLER;
         tick_ff      <= '0;
         step_ff      <= '0;
         pins_ff      <= '0;
         uptime_ff    <= '0;
         stop_ff      <= '0;
         for (int i = 0; i < NUM_SERVOS; i++) begin
            pos_ff[i] <= CENTRE_POS;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff  <= phase_in;
            tick_ff   <= tick_in;
            step_ff   <= step_in;
            pins_ff   <= pins_in;
            uptime_ff <= uptime_in;
            stop_ff   <= stop_in;
            pos_ff    <= pos_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_pin_z_ff        <= pins_in[0];
         rsp_pin_x_ff        <= pin_x_next;
         rsp_read_value_ff   <= rd_value;
         rsp_update_pulse_ff <= 1'b0;
      end else if ((state_ff == ST_REM) && rem_status.done) begin
         rsp_update_pulse_ff <= rem_status.rem_zero;
      end
   end

   // Shared remainder unit for the update pulse
   dspg_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (uptime_in),
      .divisor  (update_interval_ff),
      .status   (rem_status)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pin_z        = rsp_pin_z_ff;
   assign rsp_pin_x        = rsp_pin_x_ff;
   assign rsp_read_value   = rsp_read_value_ff;
   assign rsp_update_pulse = rsp_update_pulse_ff;

   // No result is shown while the remainder is still being worked out
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REM) |-> !rsp_valid_ff)
      else $error("result shown during remainder run");

   // The remainder unit finishes only when the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      rem_status.done |-> (state_ff == ST_REM))
      else $error("remainder done outside its run");

   // A pin rises only on an item that starts a frame
   assert property (@(posedge clock) disable iff (reset)
      (|(pins_ff & ~$past(pins_ff))) |-> $past(req_fire && frame_start))
      else $error("pin raised outside frame start");

   // An update pulse is only ever reported with a valid result
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_update_pulse_ff) |-> rsp_valid_ff)
      else $error("update pulse without result");

endmodule

// ===== tb/servo_pulse_checker.sv =====
// Checker for the dual servo pulse generator: tracks frame timing, positions and timeout
// from the accepted items and register writes, and compares every result item in order.
// Depends on dspg_pkg; instantiated by testbench beside the block.
`timescale 1ns / 1ps

module servo_pulse_checker
   import dspg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [ID_W-1:0]       req_servo_id,
   input  logic [POS_W-1:0]      req_position,
   input  logic [TMO_W-1:0]      req_timeout_ms,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_pin_z,
   input  logic                  rsp_pin_x,
   input  logic [POS_W-1:0]      rsp_read_value,
   input  logic                  rsp_update_pulse,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           fail_count,
   output int unsigned           outcomes_due
);

   localparam int              SERVOS  = 2;

   typedef struct packed {
      logic             pin_z;
      logic             pin_x;
      logic [POS_W-1:0] read_value;
      logic             update_pulse;
   } servo_outcome_type;

   // register copies
   logic                  rev_z;
   logic [POS_W-1:0]      off_code;
   logic [TICK_W-1:0]     start_delay;
   logic [TICK_W-1:0]     step_period;
   logic [TICK_W-1:0]     stop_period;
   logic [TICK_W-1:0]     stop_reps;
   logic [INTERVAL_W-1:0] upd_interval;

   // frame and servo state
   phase_type             frame_ph;
   logic [TICK_W-1:0]     tick_cnt;
   logic [TICK_W-1:0]     step_cnt;
   logic [POS_W-1:0]      held_pos  [SERVOS];
   logic                  pin_lvl   [SERVOS];
   logic [UPTIME_W-1:0]   uptime;
   logic [TMO_W-1:0]      stop_tmr;

   servo_outcome_type     outcomes_q [$];
   int unsigned           mismatches;

   assign fail_count = mismatches;

   task automatic flag(input string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %0s", what);
   endtask

   function automatic logic [POS_W-1:0] z_reversed(input logic [ID_W-1:0] id,
                                                    input logic [POS_W-1:0] p);
      if (rev_z && id == SERVO_Z && p != off_code) return ~p;
      return p;
   endfunction

   // drop every pin whose position lies below the sweep step
   function automatic void compare_pins();
      for (int i = 0; i < SERVOS; i++)
         if (held_pos[i] < step_cnt) pin_lvl[i] = 1'b0;
   endfunction

   // new frame: raise pins, count uptime, run the power-off countdown
   function automatic logic begin_frame();
      logic pulse;
      pulse = 1'b0;
      frame_ph = PH_START;
      for (int i = 0; i < SERVOS; i++)
         if (held_pos[i] != off_code) pin_lvl[i] = 1'b1;
      uptime = uptime + UPTIME_W'(FRAME_MS);
      if (upd_interval != '0 && (uptime % {16'd0, upd_interval}) == '0) pulse = 1'b1;
      if (stop_tmr != '0) begin
         stop_tmr = stop_tmr - FRAME_MS;
         if (stop_tmr < FRAME_MS) begin
            stop_tmr = '0;
            for (int i = 0; i < SERVOS; i++) held_pos[i] = off_code;
         end
      end
      return pulse;
   endfunction

   function automatic logic advance_tick();
      logic [TICK_W-1:0] period;
      if (frame_ph == PH_START)      period = start_delay;
      else if (frame_ph == PH_SWEEP) period = step_period;
      else                           period = stop_period;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt < period) return 1'b0;
      tick_cnt = '0;
      if (frame_ph == PH_START) begin
         frame_ph = PH_SWEEP;
         step_cnt = 8'd1;
         compare_pins();
      end else if (frame_ph == PH_SWEEP) begin
         step_cnt = step_cnt + 8'd1;
         if (step_cnt == '0) frame_ph = PH_FILLER;
         else compare_pins();
      end else begin
         step_cnt = step_cnt + 8'd1;
         if (step_cnt > stop_reps) return begin_frame();
      end
      return 1'b0;
   endfunction

   // result of one accepted item, updating the tracked state
   function automatic servo_outcome_type servo_outcome(input logic [MODE_W-1:0] mode,
                                                      input logic [ID_W-1:0]   id,
                                                      input logic [POS_W-1:0]  pos,
                                                      input logic [TMO_W-1:0]  tmo);
      servo_outcome_type res;
      logic [POS_W-1:0] p;
      res = '0;
      if (mode == MODE_TICK) begin
         res.update_pulse = advance_tick();
      end else if (id < SERVOS) begin
         p = z_reversed(id, pos);
         if (mode == MODE_SET) begin
            for (int i = 0; i < SERVOS; i++) held_pos[i] = (i == id) ? p : off_code;
         end else if (mode == MODE_SET_TMO) begin
            if (tmo > FRAME_MS) begin
               stop_tmr = tmo;
               held_pos[id] = p;
            end
         end else begin
            res.read_value = z_reversed(id, held_pos[id]);
         end
      end
      res.pin_z = pin_lvl[0];
      res.pin_x = pin_lvl[1];
      return res;
   endfunction

   always @(posedge clock) begin
      servo_outcome_type seen;
      servo_outcome_type want;
      if (reset) begin
         rev_z        = 1'b0;
         off_code     = '0;
         start_delay  = START_DELAY_RST;
         step_period  = STEP_TICKS_RST;
         stop_period  = STOP_PERIOD_RST;
         stop_reps    = STOP_REPEATS_RST;
         upd_interval = UPDATE_INTERVAL_RST;
         frame_ph     = PH_FILLER;
         tick_cnt     = '0;
         step_cnt     = '0;
         for (int i = 0; i < SERVOS; i++) begin
            held_pos[i] = CENTRE_POS;
            pin_lvl[i]  = 1'b0;
         end
         uptime     = '0;
         stop_tmr   = '0;
         outcomes_q.delete();
         mismatches = 0;
      end else begin
         // result side first, so a same-edge request queues behind it
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_pin_z, rsp_pin_x, rsp_read_value, rsp_update_pulse};
            if (outcomes_q.size() == 0) begin
               flag($sformatf("result item with none expected (%0h)", seen));
            end else begin
               want = outcomes_q.pop_front();
               if (seen.pin_z !== want.pin_z)
                  flag($sformatf("pin_z expected %0d, got %0d", want.pin_z, seen.pin_z));
               if (seen.pin_x !== want.pin_x)
                  flag($sformatf("pin_x expected %0d, got %0d", want.pin_x, seen.pin_x));
               if (seen.read_value !== want.read_value)
                  flag($sformatf("read_value expected %0d, got %0d",
                                 want.read_value, seen.read_value));
               if (seen.update_pulse !== want.update_pulse)
                  flag($sformatf("update_pulse expected %0d, got %0d",
                                 want.update_pulse, seen.update_pulse));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_REVERSE_Z:       rev_z        = csr_wdata[0];
               REG_POWER_OFF_CODE:  off_code     = csr_wdata[7:0];
               REG_START_DELAY:     start_delay  = csr_wdata[7:0];
               REG_STEP_TICKS:      step_period  = csr_wdata[7:0];
               REG_STOP_PERIOD:     stop_period  = csr_wdata[7:0];
               REG_STOP_REPEATS:    stop_reps    = csr_wdata[7:0];
               REG_UPDATE_INTERVAL: upd_interval = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            outcomes_q.push_back(servo_outcome(req_mode, req_servo_id,
                                               req_position, req_timeout_ms));
      end
      outcomes_due <= outcomes_q.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top of the servo pulse generator bench: clock, reset, item and register stimulus,
// random idling on both channels and the verdict. Depends on dspg_pkg,
// dual_servo_pwm_generator and servo_pulse_checker.
`timescale 1ns / 1ps

module testbench
   import dspg_pkg::*;
;

   localparam int unsigned     CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [MODE_W-1:0]     req_mode = MODE_TICK;
   logic [ID_W-1:0]       req_servo_id = '0;
   logic [POS_W-1:0]      req_position = '0;
   logic [TMO_W-1:0]      req_timeout_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_pin_z;
   logic                  rsp_pin_x;
   logic [POS_W-1:0]      rsp_read_value;
   logic                  rsp_update_pulse;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned           fail_count;
   int unsigned           outcomes_due;
   int unsigned           cycle_count = 0;
   int unsigned           rsp_stall_left = 0;
   bit                    req_up = 1'b0;
   bit                    req_calm = 1'b0;
   bit                    rsp_calm = 1'b0;
   logic [POS_W-1:0]      cur_off_code = '0;

   dual_servo_pwm_generator u_top (.*);

   servo_pulse_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: random stall after each accepted item, with calm stretches
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 8);
         rsp_ready      <= (stall == 0);
         rsp_stall_left <= stall;
      end else if (!rsp_ready) begin
         if (rsp_stall_left <= 1) rsp_ready <= 1'b1;
         rsp_stall_left <= rsp_stall_left - 1;
      end
   end

   // one item; valid stays up into the next item when no gap is drawn
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                            input logic [POS_W-1:0] pos, input logic [TMO_W-1:0] tmo);
      int gap;
      if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         if (req_up) req_valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_up          = 1'b1;
      req_mode       <= mode;
      req_servo_id   <= id;
      req_position   <= pos;
      req_timeout_ms <= tmo;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the sender until every awaited result item is in
   task automatic quiesce();
      if (req_up) req_valid <= 1'b0;
      req_up = 1'b0;
      do @(posedge clock); while (outcomes_due != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(input logic rev, input logic [7:0] off, input logic [7:0] start,
                                input logic [7:0] step, input logic [7:0] stop,
                                input logic [7:0] reps, input logic [15:0] interval);
      quiesce();
      write_reg(REG_REVERSE_Z, {15'd0, rev});
      write_reg(REG_POWER_OFF_CODE, {8'd0, off});
      write_reg(REG_START_DELAY, {8'd0, start});
      write_reg(REG_STEP_TICKS, {8'd0, step});
      write_reg(REG_STOP_PERIOD, {8'd0, stop});
      write_reg(REG_STOP_REPEATS, {8'd0, reps});
      write_reg(REG_UPDATE_INTERVAL, interval);
      csr_valid <= 1'b0;
      cur_off_code = off;
   endtask

   // tick bursts broken by commands; set commands to an absent servo are not counted
   task automatic run_random(input int unsigned count);
      int unsigned      done_items;
      int unsigned      pick;
      logic [MODE_W-1:0] mode;
      logic [ID_W-1:0]  id;
      logic [POS_W-1:0] pos;
      logic [TMO_W-1:0] tmo;
      done_items = 0;
      while (done_items < count) begin
         repeat ($urandom_range(1, 30)) begin
            send_item(MODE_TICK, ID_W'($urandom()), POS_W'($urandom()), TMO_W'($urandom()));
            done_items++;
         end
         if ($urandom_range(0, 99) == 0) quiesce();
         id  = ($urandom_range(0, 7) == 0) ? ID_W'($urandom_range(2, 3))
                                           : ID_W'($urandom_range(0, 1));
         pos = ($urandom_range(0, 5) == 0) ? cur_off_code : POS_W'($urandom());
         case ($urandom_range(0, 3))
            0:       tmo = TMO_W'($urandom_range(21, 100));
            1:       tmo = TMO_W'($urandom_range(0, 20));
            2:       tmo = TMO_W'($urandom_range(21, 60));
            default: tmo = TMO_W'($urandom());
         endcase
         pick = $urandom_range(0, 2);
         mode = (pick == 0) ? MODE_SET : (pick == 1) ? MODE_SET_TMO : MODE_READ;
         send_item(mode, id, pos, tmo);
         if (id <= SERVO_X || mode == MODE_READ) done_items++;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: reads, sets and timeout limits under reset settings
      send_item(MODE_READ, SERVO_Z, 8'd0, 16'd0);
      send_item(MODE_READ, SERVO_X, 8'd0, 16'd0);
      send_item(MODE_READ, 2'd2, 8'hff, 16'hffff);
      send_item(MODE_READ, 2'd3, 8'd0, 16'd0);
      send_item(MODE_SET, SERVO_Z, 8'd0, 16'd0);
      send_item(MODE_READ, SERVO_X, 8'd0, 16'd0);
      send_item(MODE_SET, SERVO_X, 8'd255, 16'd0);
      send_item(MODE_SET_TMO, SERVO_Z, 8'd77, 16'd0);
      send_item(MODE_SET_TMO, SERVO_Z, 8'd78, 16'd20);
      send_item(MODE_SET_TMO, SERVO_Z, 8'd79, 16'd21);
      send_item(MODE_SET_TMO, SERVO_X, 8'd80, 16'hffff);
      send_item(MODE_SET, 2'd2, 8'd11, 16'd0);
      send_item(MODE_SET_TMO, 2'd3, 8'd12, 16'd100);
      send_item(MODE_READ, SERVO_Z, 8'd0, 16'd0);

      // directed: z inversion and its power-off exception
      quiesce();
      write_reg(REG_REVERSE_Z, 16'd1);
      write_reg(REG_POWER_OFF_CODE, 16'd255);
      csr_valid <= 1'b0;
      cur_off_code = 8'd255;
      send_item(MODE_SET, SERVO_Z, 8'd10, 16'd0);
      send_item(MODE_READ, SERVO_Z, 8'd0, 16'd0);
      send_item(MODE_SET_TMO, SERVO_Z, 8'd255, 16'd30);
      send_item(MODE_READ, SERVO_Z, 8'd0, 16'd0);
      send_item(MODE_READ, SERVO_X, 8'd0, 16'd0);
      send_item(MODE_TICK, 2'd3, 8'hff, 16'hffff);
      send_item(MODE_SET, SERVO_X, 8'd3, 16'd0);
      send_item(MODE_READ, SERVO_Z, 8'd0, 16'd0);

      // shortest legal frame, pulse every frame
      load_settings(1'b1, 8'($urandom()), 8'd1, 8'd1, 8'd1, 8'd0, 16'd20);
      run_random(420);
      // slowest settings
      load_settings(1'b0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hffff);
      run_random(120);
      // zero periods act as one, zero interval gives no pulse
      load_settings(1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
      run_random(400);
      // small random settings
      load_settings(1'($urandom()), 8'($urandom()), 8'($urandom_range(1, 3)),
                    8'($urandom_range(1, 2)), 8'($urandom_range(1, 3)),
                    8'($urandom_range(0, 2)), 16'(20 * $urandom_range(1, 3)));
      run_random(410);

      quiesce();
      repeat (40) @(posedge clock);
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
